@@ hw/rtl/sliding_dft_harmonic_magnitudes_macros.svh @@
// Assertion macros shared by the sliding DFT RTL.
`ifndef SLIDING_DFT_HARMONIC_MAGNITUDES_MACROS_SVH
`define SLIDING_DFT_HARMONIC_MAGNITUDES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/sdft_pkg.sv @@
package sdft_pkg;

   // Fixed sizes of the transform.
   localparam int WINDOW_LEN  = 64;
   localparam int NUM_BINS    = 14;
   localparam int SAMPLE_BITS = 16;

   localparam int POS_W   = $clog2(WINDOW_LEN);
   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int IDX_W   = 4;
   localparam int MAG_W   = 16;
   localparam int TW_W    = 18;
   localparam int ACC_W   = 40;
   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int A_W     = ACC_W + 1;
   localparam int PROD_W  = TW_W + A_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int RND_SH  = TW_W - 1;
   localparam int SHR_W   = SUM_W - RND_SH;
   localparam int OVF_BIT = 35;
   localparam int HALF_W  = OVF_BIT - 4;
   localparam int SQ_W    = 2 * HALF_W;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int CNT_W   = $clog2(ROOT_W);
   localparam int MAG_SHIFT = $clog2(16 * WINDOW_LEN);
   localparam int MAG_ROUND = 8 * WINDOW_LEN;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_MA, S_MB, S_MC, S_MD, S_ME,
      S_SQA, S_SQB, S_ROOT, S_WAIT, S_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIFF, OP_MA, OP_MB, OP_MC, OP_MD, OP_ME,
      OP_SQA, OP_SQB, OP_ROOT, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [BIN_W-1:0] bin;
   } dp_cmd_type;

   typedef struct packed {
      logic root_done;
      logic out_free;
   } dp_status_type;

   // Cosine of 2*pi*k/WINDOW_LEN in Q1.17.
   function automatic logic signed [TW_W-1:0] tw_cos(input logic [BIN_W-1:0] k);
      logic signed [TW_W-1:0] v;
      unique case (k)
         4'd0:    v = 18'sd131071;
         4'd1:    v = 18'sd130441;
         4'd2:    v = 18'sd128553;
         4'd3:    v = 18'sd125428;
         4'd4:    v = 18'sd121095;
         4'd5:    v = 18'sd115595;
         4'd6:    v = 18'sd108982;
         4'd7:    v = 18'sd101320;
         4'd8:    v = 18'sd92682;
         4'd9:    v = 18'sd83151;
         4'd10:   v = 18'sd72820;
         4'd11:   v = 18'sd61787;
         4'd12:   v = 18'sd50159;
         4'd13:   v = 18'sd38048;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Sine of 2*pi*k/WINDOW_LEN in Q1.17.
   function automatic logic signed [TW_W-1:0] tw_sin(input logic [BIN_W-1:0] k);
      logic signed [TW_W-1:0] v;
      unique case (k)
         4'd0:    v = 18'sd0;
         4'd1:    v = 18'sd12847;
         4'd2:    v = 18'sd25571;
         4'd3:    v = 18'sd38048;
         4'd4:    v = 18'sd50159;
         4'd5:    v = 18'sd61787;
         4'd6:    v = 18'sd72820;
         4'd7:    v = 18'sd83151;
         4'd8:    v = 18'sd92682;
         4'd9:    v = 18'sd101320;
         4'd10:   v = 18'sd108982;
         4'd11:   v = 18'sd115595;
         4'd12:   v = 18'sd121095;
         4'd13:   v = 18'sd125428;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/sdft_isqrt.sv @@
`include "sliding_dft_harmonic_magnitudes_macros.svh"

// Bit-serial integer square root, one result bit per cycle.
module sdft_isqrt import sdft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              active_ff, active_in;
   logic              done_ff, done_in;

   logic [ROOT_W+3:0] rem_sh;
   logic [ROOT_W+3:0] trial;
   logic              fits;

   // One restoring step: bring down two radicand bits and try a one.
   always_comb begin
      rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      fits   = rem_sh >= trial;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      active_in = active_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in    = radicand;
         rem_in    = '0;
         root_in   = '0;
         cnt_in    = CNT_W'(ROOT_W - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   `SDFT_ASSERT_NEXT(a_start_runs, clock, reset, start, active_ff && !done_ff, "isqrt did not start")

endmodule

@@ hw/rtl/sdft_datapath.sv @@
`include "sliding_dft_harmonic_magnitudes_macros.svh"

// Sample window, bin accumulators, multipliers and the result register.
module sdft_datapath import sdft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [IDX_W-1:0]       rsp_bin_index,
   output logic [MAG_W-1:0]       rsp_magnitude,
   output logic                   rsp_last_bin
);

   logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_LEN];
   logic [POS_W-1:0]              pos_ff;
   logic                          full_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic signed [DIFF_W-1:0]      d_ff;
   logic signed [ACC_W-1:0]       re_ff [NUM_BINS];
   logic signed [ACC_W-1:0]       im_ff [NUM_BINS];
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [ACC_W-1:0]       tr_ff, ti_ff;
   logic [SQ_W-1:0]               sq_ff;
   logic [SQ_W:0]                 sqs_ff;
   logic                          ov_ff;
   logic                          rsp_valid_ff;
   logic [IDX_W-1:0]              rsp_bin_ff;
   logic [MAG_W-1:0]              rsp_mag_ff;
   logic                          rsp_last_ff;

   logic signed [TW_W-1:0]   tw_c, tw_s, mul_a;
   logic signed [A_W-1:0]    acc_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  tr_next, ti_next;
   logic [ACC_W-1:0]         mag_r, mag_i;
   logic [HALF_W-1:0]        sq_in;
   logic [SQ_W-1:0]          sq_prod;
   logic [RAD_W-1:0]         radicand;
   logic                     root_done;
   logic [ROOT_W-1:0]        root;
   logic [ROOT_W:0]          q_full;
   logic [MAG_W-1:0]         mag_sat;
   logic                     out_free;

   // Round half up from the twiddle fraction bits and clamp to the accumulator range.
   function automatic logic signed [ACC_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      logic signed [SHR_W-1:0] sh;
      r  = v + SUM_W'(1 << (RND_SH - 1));
      sh = r[SUM_W-1:RND_SH];
      if (sh[SHR_W-1:ACC_W-1] == '0 || sh[SHR_W-1:ACC_W-1] == '1) begin
         return sh[ACC_W-1:0];
      end else if (sh[SHR_W-1]) begin
         return {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         return {1'b0, {(ACC_W-1){1'b1}}};
      end
   endfunction

   // Complex rotation: one shared multiplier, operands picked by step.
   always_comb begin
      tw_c  = tw_cos(cmd.bin);
      tw_s  = tw_sin(cmd.bin);
      acc_a = A_W'(re_ff[cmd.bin]) + (A_W'(d_ff) <<< 8);
      unique case (cmd.op)
         OP_MB:   begin mul_a = tw_s; mul_b = A_W'(im_ff[cmd.bin]); end
         OP_MC:   begin mul_a = tw_s; mul_b = acc_a; end
         OP_MD:   begin mul_a = tw_c; mul_b = A_W'(im_ff[cmd.bin]); end
         default: begin mul_a = tw_c; mul_b = acc_a; end
      endcase
      prod    = PROD_W'(mul_a * mul_b);
      tr_next = round_sat(sum_ff - SUM_W'(prod_ff));
      ti_next = round_sat(sum_ff + SUM_W'(prod_ff));
   end

   // Magnitude: absolute values, squares, then the scaled root.
   always_comb begin
      mag_r    = tr_ff[ACC_W-1] ? ACC_W'(-tr_ff) : ACC_W'(tr_ff);
      mag_i    = ti_ff[ACC_W-1] ? ACC_W'(-ti_ff) : ACC_W'(ti_ff);
      sq_in    = (cmd.op == OP_SQA) ? mag_r[OVF_BIT-1:4] : mag_i[OVF_BIT-1:4];
      sq_prod  = SQ_W'(sq_in * sq_in);
      radicand = RAD_W'({(SQ_W+1)'(sqs_ff + (SQ_W+1)'(sq_ff)), 1'b0});
      q_full   = (ROOT_W+1)'(((ROOT_W+1)'(root) + (ROOT_W+1)'(MAG_ROUND)) >> MAG_SHIFT);
      if (ov_ff || q_full[ROOT_W:MAG_W] != '0) begin
         mag_sat = '1;
      end else begin
         mag_sat = q_full[MAG_W-1:0];
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   sdft_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_ROOT),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // Window memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         rd_ff <= full_ff ? window_mem[pos_ff] : '0;
      end
      if (cmd.op == OP_DIFF) begin
         window_mem[pos_ff] <= sample_ff;
      end
   end

   // Write position and fill state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         full_ff <= 1'b0;
      end else if (cmd.op == OP_DIFF) begin
         pos_ff <= (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
         if (pos_ff == POS_W'(WINDOW_LEN - 1)) begin
            full_ff <= 1'b1;
         end
      end
   end

   // Bin accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            re_ff[i] <= '0;
            im_ff[i] <= '0;
         end
      end else if (cmd.op == OP_ME) begin
         re_ff[cmd.bin] <= tr_ff;
         im_ff[cmd.bin] <= ti_next;
      end
   end

   // Pipeline registers of the arithmetic steps.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: sample_ff <= req_sample;
         OP_DIFF: d_ff <= DIFF_W'(rd_ff) - DIFF_W'(sample_ff);
         OP_MA:   prod_ff <= prod;
         OP_MB:   begin sum_ff <= SUM_W'(prod_ff); prod_ff <= prod; end
         OP_MC:   begin tr_ff <= tr_next; prod_ff <= prod; end
         OP_MD:   begin sum_ff <= SUM_W'(prod_ff); prod_ff <= prod; end
         OP_ME:   ti_ff <= ti_next;
         OP_SQA:  begin
            sq_ff <= sq_prod;
            ov_ff <= (mag_r[ACC_W-1:OVF_BIT] != '0) || (mag_i[ACC_W-1:OVF_BIT] != '0);
         end
         OP_SQB:  begin sqs_ff <= (SQ_W+1)'(sq_ff); sq_ff <= sq_prod; end
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_EMIT && out_free) begin
         rsp_bin_ff  <= IDX_W'(cmd.bin);
         rsp_mag_ff  <= mag_sat;
         rsp_last_ff <= (cmd.bin == BIN_W'(NUM_BINS - 1));
      end
   end

   assign status.root_done = root_done;
   assign status.out_free  = out_free;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_last_bin  = rsp_last_ff;

   `SDFT_ASSERT_NEXT(a_emit_loads, clock, reset, cmd.op == OP_EMIT && out_free, rsp_valid_ff, "result not loaded")

endmodule

@@ hw/rtl/sdft_ctrl.sv @@
`include "sliding_dft_harmonic_magnitudes_macros.svh"

// Sequencer: one sample, then each bin through rotate, square, root and emit.
module sdft_ctrl import sdft_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [BIN_W-1:0] bin_ff, bin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bin_ff   <= bin_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      cmd.op    = OP_NONE;
      cmd.bin   = bin_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            bin_in   = '0;
            state_in = S_MA;
         end
         S_MA:   begin cmd.op = OP_MA;   state_in = S_MB;   end
         S_MB:   begin cmd.op = OP_MB;   state_in = S_MC;   end
         S_MC:   begin cmd.op = OP_MC;   state_in = S_MD;   end
         S_MD:   begin cmd.op = OP_MD;   state_in = S_ME;   end
         S_ME:   begin cmd.op = OP_ME;   state_in = S_SQA;  end
         S_SQA:  begin cmd.op = OP_SQA;  state_in = S_SQB;  end
         S_SQB:  begin cmd.op = OP_SQB;  state_in = S_ROOT; end
         S_ROOT: begin cmd.op = OP_ROOT; state_in = S_WAIT; end
         S_WAIT: begin
            if (status.root_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.op = OP_EMIT;
            if (status.out_free) begin
               if (bin_ff == BIN_W'(NUM_BINS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  state_in = S_MA;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `SDFT_ASSERT_NEXT(a_root_to_emit, clock, reset, state_ff == S_WAIT && status.root_done, state_ff == S_EMIT, "root done but no emit")
   `SDFT_ASSERT_NEXT(a_last_bin_idle, clock, reset, state_ff == S_EMIT && status.out_free && bin_ff == BIN_W'(NUM_BINS - 1), state_ff == S_IDLE, "last bin did not end item")
   `SDFT_ASSERT_SAME(a_bin_range, clock, reset, state_ff != S_IDLE, bin_ff <= BIN_W'(NUM_BINS - 1), "bin counter out of range")

endmodule

@@ hw/rtl/sliding_dft_harmonic_magnitudes.sv @@
// Channel | Direction | Ports                                         | Moves
// req     | in        | req_valid, req_ready, req_sample              | one sample
// rsp     | out       | rsp_valid, rsp_ready, rsp_bin_index,          | one bin result
//         |           | rsp_magnitude, rsp_last_bin                   |
// A sample enters through the load and difference steps, then each bin takes the rotation
// steps on the shared multiplier, the squarer, the bit-serial square root and the emit step.
// Each item covers all 14 bins; req_ready is high only between items.
// Reset is synchronous and clears the window fill state, accumulators and control.
// A stalled rsp channel holds the sequencer in its emit step until the result register frees.
module sliding_dft_harmonic_magnitudes import sdft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [IDX_W-1:0]       rsp_bin_index,
   output logic [MAG_W-1:0]       rsp_magnitude,
   output logic                   rsp_last_bin
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sdft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdft_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_magnitude (rsp_magnitude),
      .rsp_last_bin  (rsp_last_bin)
   );

endmodule
